>>> rtl/flb_pkg.sv
// shared types, constants and codes of the flow session load balancer
`default_nettype none

package flb_pkg;

   localparam int SERVERS_DEF     = 4;
   localparam int SESSIONS_DEF    = 256;
   localparam int PROBE_LIMIT_DEF = 8;

   localparam int ENDPOINTS  = 4;
   localparam int ADDR_W     = 32;
   localparam int PROTO_W    = 8;
   localparam int PORT_W     = 16;
   localparam int KEY_W      = ADDR_W + PROTO_W + PORT_W;
   localparam int BACKEND_W  = ADDR_W + PORT_W;
   localparam int HASH_W     = 16;
   localparam int COUNT_W    = 3;
   localparam int RR_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_SERVER_COUNT  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ENDPOINT_LAST = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      RES_FOUND   = 3'd0,
      RES_CREATED = 3'd1,
      RES_MISS    = 3'd2,
      RES_REFUSED = 3'd3,
      RES_FULL    = 3'd4
   } result_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_LOAD,
      ST_PROBE,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       reduce;
      logic       load_slot;
      logic       advance;
      logic       write;
      logic       clear;
      logic       set_result;
      result_type code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic refuse_now;
      logic no_reduce;
      logic reduce_last;
      logic create;
      logic hit;
      logic empty;
      logic last;
      logic clear_last;
      logic rsp_free;
   } stat_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [BACKEND_W-1:0] backend;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/flb_datapath.sv
// session table memory, hashing, probe walk, round-robin pick and result registers
`default_nettype none

module flb_datapath import flb_pkg::*; #(
   parameter int SERVERS     = SERVERS_DEF,
   parameter int SESSIONS    = SESSIONS_DEF,
   parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cmd_type                          cmd,
   output stat_type                         stat,
   input  logic                             req_type,
   input  logic [ADDR_W-1:0]                req_client_addr,
   input  logic [PROTO_W-1:0]               req_flow_protocol,
   input  logic [PORT_W-1:0]                req_client_port,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic [ADDR_W-1:0]                rsp_backend_addr,
   output logic [PORT_W-1:0]                rsp_backend_port,
   input  logic [COUNT_W-1:0]               server_count,
   input  logic [ENDPOINTS-1:0][BACKEND_W-1:0] endpoints
);

   localparam int SLOT_W       = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int PROBE_W      = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
   localparam bit IS_POW2      = ((SESSIONS & (SESSIONS - 1)) == 0);
   localparam int REDUCE_STEPS = IS_POW2 ? 0 : $clog2((1 << HASH_W) / SESSIONS + 1);
   localparam int DIV_SHIFT    = (REDUCE_STEPS > 0) ? REDUCE_STEPS - 1 : 0;
   localparam logic [HASH_W:0] DIV_TOP  = (HASH_W + 1)'(SESSIONS * (1 << DIV_SHIFT));
   localparam logic [HASH_W:0] DIV_LAST = (HASH_W + 1)'(SESSIONS);
   localparam int IN_USE_MAX   = (SERVERS < ENDPOINTS) ? SERVERS : ENDPOINTS;

   entry_type entry_mem [SESSIONS];
   entry_type rd_data_ff;

   logic                 type_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [KEY_W-1:0]     key_in;
   logic [HASH_W-1:0]    hash_ff;
   logic [HASH_W-1:0]    hash_in;
   logic [HASH_W-1:0]    fold_in;
   logic [HASH_W:0]      div_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;
   logic [PROBE_W-1:0]   probe_cnt_ff;
   logic [SLOT_W-1:0]    clr_addr_ff;
   logic [RR_W-1:0]      rr_ff;
   logic [RR_W-1:0]      rr_in;
   logic [BACKEND_W-1:0] pick_ff;
   result_type           res_code_ff;
   logic [BACKEND_W-1:0] res_backend_ff;
   logic [BACKEND_W-1:0] res_backend_in;
   logic                 rsp_valid_ff;
   result_type           rsp_status_ff;
   logic [BACKEND_W-1:0] rsp_backend_ff;

   logic [COUNT_W-1:0]   in_use;
   logic [RR_W-1:0]      pick;
   logic [COUNT_W-1:0]   pick_inc;

   assign key_in  = {req_client_addr, req_flow_protocol, req_client_port};
   assign fold_in = key_in[15:0] ^ key_in[31:16] ^ key_in[47:32]
                  ^ {{(HASH_W - (KEY_W - 48)){1'b0}}, key_in[KEY_W-1:48]};

   // servers in use, limited by the parameter and the endpoint registers
   assign in_use   = (server_count > COUNT_W'(IN_USE_MAX)) ? COUNT_W'(IN_USE_MAX)
                                                           : server_count;
   assign pick     = ({1'b0, rr_ff} < in_use) ? rr_ff : '0;
   assign pick_inc = {1'b0, pick} + COUNT_W'(1);
   assign rr_in    = (pick_inc >= in_use) ? '0 : pick_inc[RR_W-1:0];

   // one restoring subtract step of the home slot modulo
   always_comb begin
      hash_in = hash_ff;
      if ({1'b0, hash_ff} >= div_ff) begin
         hash_in = hash_ff - div_ff[HASH_W-1:0];
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (cmd.load_slot) begin
         slot_in = hash_ff[SLOT_W-1:0];
      end else if (cmd.advance) begin
         slot_in = (slot_ff == SLOT_W'(SESSIONS - 1)) ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      case (cmd.code)
         RES_FOUND:   res_backend_in = rd_data_ff.backend;
         RES_CREATED: res_backend_in = pick_ff;
         default:     res_backend_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         key_ff  <= key_in;
         hash_ff <= fold_in;
         div_ff  <= DIV_TOP;
      end else if (cmd.reduce) begin
         hash_ff <= hash_in;
         div_ff  <= div_ff >> 1;
      end
      slot_ff <= slot_in;
      if (cmd.load_slot) begin
         probe_cnt_ff <= '0;
      end else if (cmd.advance) begin
         probe_cnt_ff <= probe_cnt_ff + PROBE_W'(1);
      end
      if (cmd.accept && req_type && (in_use != '0)) begin
         pick_ff <= endpoints[pick];
      end
      if (cmd.set_result) begin
         res_code_ff    <= cmd.code;
         res_backend_ff <= res_backend_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= res_code_ff;
         rsp_backend_ff <= res_backend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.accept && req_type && (in_use != '0)) begin
            rr_ff <= rr_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         end
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         entry_mem[clr_addr_ff] <= '0;
      end else if (cmd.write) begin
         entry_mem[slot_ff] <= '{valid: 1'b1, key: key_ff, backend: pick_ff};
      end
      rd_data_ff <= entry_mem[slot_in];
   end

   assign stat.refuse_now  = req_type && (in_use == '0);
   assign stat.no_reduce   = IS_POW2;
   assign stat.reduce_last = (div_ff == DIV_LAST);
   assign stat.create      = type_ff;
   assign stat.hit         = rd_data_ff.valid && (rd_data_ff.key == key_ff);
   assign stat.empty       = !rd_data_ff.valid;
   assign stat.last        = (probe_cnt_ff == PROBE_W'(PROBE_LIMIT - 1));
   assign stat.clear_last  = (clr_addr_ff == SLOT_W'(SESSIONS - 1));
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_backend_addr = rsp_backend_ff[BACKEND_W-1:PORT_W];
   assign rsp_backend_port = rsp_backend_ff[PORT_W-1:0];

   // a session is only stored into a slot the probe found empty, on a create
   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rd_data_ff.valid && type_ff))
      else $error("session write into an occupied slot");

   // the output register is never overwritten while a word still waits
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending word");

endmodule

`default_nettype wire

>>> rtl/flb_ctrl.sv
// request sequencer of the flow session load balancer
`default_nettype none

module flb_ctrl import flb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.code  = RES_FOUND;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.refuse_now) begin
                  cmd.set_result = 1'b1;
                  cmd.code       = RES_REFUSED;
                  state_in       = ST_RESP;
               end else if (stat.no_reduce) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (stat.reduce_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_slot = 1'b1;
            state_in      = ST_PROBE;
         end
         ST_PROBE: begin
            // read of the next slot is issued while this one is checked
            if (stat.hit) begin
               cmd.set_result = 1'b1;
               cmd.code       = stat.create ? RES_REFUSED : RES_FOUND;
               state_in       = ST_RESP;
            end else if (stat.empty) begin
               if (stat.create) begin
                  state_in = ST_WRITE;
               end else begin
                  cmd.set_result = 1'b1;
                  cmd.code       = RES_MISS;
                  state_in       = ST_RESP;
               end
            end else if (stat.last) begin
               cmd.set_result = 1'b1;
               cmd.code       = stat.create ? RES_FULL : RES_MISS;
               state_in       = ST_RESP;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.write      = 1'b1;
            cmd.set_result = 1'b1;
            cmd.code       = RES_CREATED;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_write_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> $past(state_ff == ST_PROBE))
      else $error("table write not preceded by a probe");

   a_hit_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && stat.hit) |=> (state_ff == ST_RESP))
      else $error("probe hit did not end the walk");

endmodule

`default_nettype wire

>>> rtl/flow_session_load_balancer.sv
// top level: register file, sequencer and datapath of the flow session load balancer
`default_nettype none

// Layer-4 session table with round-robin backend choice. A request word carries
// req_type (0 lookup, 1 create) and the flow key; exactly one result word comes
// back with status 0 found, 1 created, 2 miss, 3 no servers or duplicate,
// 4 table full, and the backend address and port (zero unless found or created).
// A create with no servers in use is accepted and its result handed straight
// to the output register. Any other request is accepted, forms its home slot,
// probes at most PROBE_LIMIT slots (each a registered read of the table
// memory), writes a new session into an empty slot on a create and hands
// the result to the output register. With a SESSIONS that is not a power of
// two the home slot modulo adds one subtract step per quotient bit. A result
// held in the output register does not block the next request. After reset
// the table is swept clear slot by slot, and no request is taken until then;
// registers can be written at any time. Registers sit at byte offsets 8*i:
// server_count at 0x00 and the four endpoints (address in bits 47..16, port
// in bits 15..0) at 0x08-0x20.

module flow_session_load_balancer import flb_pkg::*; #(
   parameter int SERVERS     = SERVERS_DEF,
   parameter int SESSIONS    = SESSIONS_DEF,
   parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [ADDR_W-1:0]     req_client_addr,
   input  logic [PROTO_W-1:0]    req_flow_protocol,
   input  logic [PORT_W-1:0]     req_client_port,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0]     rsp_backend_addr,
   output logic [PORT_W-1:0]     rsp_backend_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0]                  server_count_ff;
   logic [ENDPOINTS-1:0][BACKEND_W-1:0] endpoint_ff;
   logic [REG_IDX_W-1:0]                reg_idx;
   logic                                csr_write;
   cmd_type                             cmd;
   stat_type                            stat;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= '0;
         endpoint_ff     <= '0;
      end else if (csr_write) begin
         if (reg_idx == REG_SERVER_COUNT) begin
            server_count_ff <= csr_pwdata[COUNT_W-1:0];
         end else if (reg_idx <= REG_ENDPOINT_LAST) begin
            endpoint_ff[reg_idx[1:0] - 2'd1] <= csr_pwdata[BACKEND_W-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_SERVER_COUNT) begin
         csr_prdata = {{(CSR_DATA_W - COUNT_W){1'b0}}, server_count_ff};
      end else if (reg_idx <= REG_ENDPOINT_LAST) begin
         csr_prdata = {{(CSR_DATA_W - BACKEND_W){1'b0}}, endpoint_ff[reg_idx[1:0] - 2'd1]};
      end
   end

   flb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   flb_datapath #(
      .SERVERS     (SERVERS),
      .SESSIONS    (SESSIONS),
      .PROBE_LIMIT (PROBE_LIMIT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_client_addr   (req_client_addr),
      .req_flow_protocol (req_flow_protocol),
      .req_client_port   (req_client_port),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_backend_addr  (rsp_backend_addr),
      .rsp_backend_port  (rsp_backend_port),
      .server_count      (server_count_ff),
      .endpoints         (endpoint_ff)
   );

endmodule

`default_nettype wire
